>>> rtl/core/tlbc_pkg.sv
package tlbc_pkg;

  // Store geometry
  localparam int ENTRIES     = 16;
  localparam int HAND_W      = $clog2(ENTRIES);

  // Field widths
  localparam int OPCODE_W    = 2;
  localparam int VA_W        = 16;
  localparam int PAGE_W      = 6;
  localparam int OFFSET_W    = 10;
  localparam int FRAME_W     = 14;
  localparam int PROT_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int PA_W        = FRAME_W + OFFSET_W;
  localparam int WA_W        = PAGE_W + 2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_TRANSLATE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REPLY     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK      = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_PROT  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_WALK  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_SEGV  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TICK  = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_STRAY = 3'd5;

  // All of read, write and execute set
  localparam logic [PROT_W-1:0] PROT_ALL = 3'd7;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VA_W-1:0]     virtual_address;
    logic [FRAME_W-1:0]  pte_frame;
    logic                pte_valid;
    logic [PROT_W-1:0]   pte_protection;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PA_W-1:0]     physical_address;
    logic [WA_W-1:0]     walk_address;
  } result_t;

  typedef enum logic [1:0] {
    KIND_TRANSLATE,
    KIND_REPLY,
    KIND_TICK
  } item_kind_t;

  // Classified item handed from front to back
  typedef struct packed {
    item_kind_t          kind;
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    logic [FRAME_W-1:0]  frame;
    logic                valid;
    logic [PROT_W-1:0]   prot;
  } work_item_t;

  typedef enum logic {
    BK_IDLE,
    BK_SWEEP
  } back_state_t;

endpackage

>>> rtl/core/tlbc_front.sv
module tlbc_front import tlbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  request_t   request,
  output logic       q_empty,
  input  logic       q_pop,
  output work_item_t q_item
);

  work_item_t           slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QCNT_W-1:0]    count;
  work_item_t           item_dec;
  logic                 keep;
  logic                 do_write;
  logic                 do_read;

  // Classify the incoming request; drop unknown opcodes
  always_comb begin
    item_dec        = '0;
    item_dec.page   = request.virtual_address[VA_W-1:OFFSET_W];
    item_dec.offset = request.virtual_address[OFFSET_W-1:0];
    item_dec.frame  = request.pte_frame;
    item_dec.valid  = request.pte_valid;
    item_dec.prot   = request.pte_protection;
    keep            = 1'b1;
    unique case (request.opcode)
      OP_TRANSLATE: item_dec.kind = KIND_TRANSLATE;
      OP_REPLY:     item_dec.kind = KIND_REPLY;
      OP_TICK:      item_dec.kind = KIND_TICK;
      default: begin
        item_dec.kind = KIND_TICK;
        keep          = 1'b0;
      end
    endcase
  end

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_empty  = (count == '0);
  assign do_write = push && !full && keep;
  assign do_read  = q_pop && !q_empty;
  assign q_item   = slot[rd_ptr];

  // Hold classified items until the back takes them
  always_ff @(posedge clk) begin
    if (do_write) begin
      slot[wr_ptr] <= item_dec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_read) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_write && !do_read) begin
        count <= count + 1'b1;
      end else if (!do_write && do_read) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/tlbc_back.sv
module tlbc_back import tlbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  output logic       q_pop,
  input  work_item_t q_item,
  output logic       empty,
  input  logic       pop,
  output result_t    result
);

  back_state_t         state;
  back_state_t         state_next;

  logic [PAGE_W-1:0]   entry_page       [ENTRIES];
  logic [FRAME_W-1:0]  entry_frame      [ENTRIES];
  logic [PROT_W-1:0]   entry_protection [ENTRIES];
  logic [ENTRIES-1:0]  occupied;
  logic [ENTRIES-1:0]  used;
  logic [HAND_W-1:0]   hand;
  logic [HAND_W-1:0]   hand_adv;
  logic [VA_W-1:0]     pending_address;
  logic                pending_flag;

  logic [PAGE_W-1:0]   hold_page;
  logic [OFFSET_W-1:0] hold_offset;
  logic [FRAME_W-1:0]  hold_frame;
  logic [PROT_W-1:0]   hold_prot;

  logic                res_valid;
  result_t             res;
  result_t             res_next;

  logic                res_free;
  logic                take;
  logic                hit;
  logic [HAND_W-1:0]   hit_idx;
  logic                reply_insert;
  logic                ins_req;
  logic                step_clear;
  logic                step_write;
  logic                res_load;
  logic [PAGE_W-1:0]   ins_page;
  logic [OFFSET_W-1:0] ins_offset;
  logic [FRAME_W-1:0]  ins_frame;
  logic [PROT_W-1:0]   ins_prot;

  assign res_free = !res_valid || pop;
  assign hand_adv = (hand == HAND_W'(ENTRIES - 1)) ? '0 : hand + 1'b1;

  // Search all entries; lowest-numbered occupied match wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (occupied[i] && (entry_page[i] == q_item.page)) begin
        hit     = 1'b1;
        hit_idx = HAND_W'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take && reply_insert && used[hand]) begin
          state_next = BK_SWEEP;
        end
      end
      BK_SWEEP: begin
        if (!used[hand]) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    take         = 1'b0;
    reply_insert = (q_item.kind == KIND_REPLY) && pending_flag && q_item.valid &&
                   (q_item.prot != PROT_ALL);
    ins_req      = 1'b0;
    ins_page     = pending_address[VA_W-1:OFFSET_W];
    ins_offset   = pending_address[OFFSET_W-1:0];
    ins_frame    = q_item.frame;
    ins_prot     = q_item.prot;
    unique case (state)
      BK_IDLE: begin
        take    = !q_empty && res_free;
        ins_req = take && reply_insert;
      end
      BK_SWEEP: begin
        ins_req    = 1'b1;
        ins_page   = hold_page;
        ins_offset = hold_offset;
        ins_frame  = hold_frame;
        ins_prot   = hold_prot;
      end
      default: begin
        take = 1'b0;
      end
    endcase
    step_clear = ins_req && used[hand];
    step_write = ins_req && !used[hand];
    res_load   = (take && !step_clear) || (state == BK_SWEEP && step_write);
  end

  assign q_pop = take;

  // Form the result of this cycle's work
  always_comb begin
    res_next = '0;
    if (ins_req) begin
      res_next.status           = STATUS_OK;
      res_next.physical_address = {ins_frame, ins_offset};
    end else begin
      unique case (q_item.kind)
        KIND_TRANSLATE: begin
          if (!hit) begin
            res_next.status       = STATUS_WALK;
            res_next.walk_address = {q_item.page, 2'b00};
          end else if (entry_protection[hit_idx] == PROT_ALL) begin
            res_next.status = STATUS_PROT;
          end else begin
            res_next.status           = STATUS_OK;
            res_next.physical_address = {entry_frame[hit_idx], q_item.offset};
          end
        end
        KIND_REPLY: begin
          if (!pending_flag) begin
            res_next.status = STATUS_STRAY;
          end else if (!q_item.valid) begin
            res_next.status = STATUS_SEGV;
          end else begin
            res_next.status = STATUS_PROT;
          end
        end
        KIND_TICK: res_next.status = STATUS_TICK;
        default:   res_next.status = STATUS_STRAY;
      endcase
    end
  end

  // Write entry payload at the hand
  always_ff @(posedge clk) begin
    if (step_write) begin
      entry_page[hand]       <= ins_page;
      entry_frame[hand]      <= ins_frame;
      entry_protection[hand] <= ins_prot;
    end
  end

  // Hold the pending request and the insert under sweep
  always_ff @(posedge clk) begin
    if (take && q_item.kind == KIND_TRANSLATE && !hit) begin
      pending_address <= {q_item.page, q_item.offset};
    end
    if (take) begin
      hold_page   <= pending_address[VA_W-1:OFFSET_W];
      hold_offset <= pending_address[OFFSET_W-1:0];
      hold_frame  <= q_item.frame;
      hold_prot   <= q_item.prot;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      occupied     <= '0;
      used         <= '0;
      hand         <= '0;
      pending_flag <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        unique case (q_item.kind)
          KIND_TRANSLATE: begin
            if (hit) begin
              used[hit_idx] <= 1'b1;
            end else begin
              pending_flag <= 1'b1;
            end
          end
          KIND_REPLY: pending_flag <= 1'b0;
          KIND_TICK:  used         <= '0;
          default:    pending_flag <= pending_flag;
        endcase
      end
      if (step_clear) begin
        used[hand] <= 1'b0;
        hand       <= hand_adv;
      end
      if (step_write) begin
        occupied[hand] <= 1'b1;
        used[hand]     <= 1'b1;
        hand           <= hand_adv;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign empty  = !res_valid;
  assign result = res;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || pop))
    else $error("result register overwritten before pop");

  a_used_implies_occupied: assert property (@(posedge clk) disable iff (rst)
    (used & ~occupied) == '0)
    else $error("use bit set on an empty entry");

  a_no_take_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SWEEP) |-> !q_pop)
    else $error("item taken during clock sweep");

  a_reply_clears_pending: assert property (@(posedge clk) disable iff (rst)
    (take && q_item.kind == KIND_REPLY) |=> !pending_flag)
    else $error("pending request survived a reply");
`endif

endmodule

>>> rtl/core/tlb_translate_clock_replace_top.sv
// Fully associative 16-entry TLB with clock replacement. Requests enter through a
// queue-style port (push/full) and results leave through one (empty/pop), one result
// per translate, reply or tick request; opcode 3 is dropped with no result. A hit,
// a miss (walk needed), a tick and a rejected reply each finish with no sweep in the
// back end. A reply that inserts first moves the clock hand past up to 16 used entries,
// clearing their use bits, then writes the entry. A two-deep queue lets requests
// keep arriving while the back end sweeps or a result waits to be popped.
module tlb_translate_clock_replace_top import tlbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  request_t request,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  logic       q_empty;
  logic       q_pop;
  work_item_t q_item;

  tlbc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  tlbc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

>>> tb/tlb_translate_clock_replace_top_test.sv
`timescale 1ns / 100ps

module tlb_translate_clock_replace_top_test;
  import tlbc_pkg::*;

  // Opcode that the block drops without a result
  localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
  localparam int RANDOM_REQUESTS = 1250;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    request_t req;
    int       gap;
    bit       drain;
  } planned_request_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     full;
  request_t request = '0;
  logic     empty;
  logic     pop = 1'b0;
  result_t  result;

  planned_request_t request_plan[$];
  result_t          translations_due[$];

  // Shadow copy of the translation buffer
  logic [PAGE_W-1:0]  shadow_page[ENTRIES];
  logic [FRAME_W-1:0] shadow_frame[ENTRIES];
  logic [PROT_W-1:0]  shadow_prot[ENTRIES];
  bit                 shadow_occupied[ENTRIES];
  bit                 shadow_used[ENTRIES];
  int                 shadow_hand;
  logic [VA_W-1:0]    held_address;
  bit                 held_valid;

  int failures = 0;
  int send_wait = 0;
  int pop_wait = 0;
  int calm_sends = 0;
  int calm_pops = 0;
  int quiet_cycles = 0;
  int hot_pages[24];

  tlb_translate_clock_replace_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Every field random, opcode forced
  function automatic request_t noisy_request(logic [OPCODE_W-1:0] op);
    request_t r;
    r.opcode          = op;
    r.virtual_address = VA_W'($urandom);
    r.pte_frame       = FRAME_W'($urandom);
    r.pte_valid       = 1'($urandom);
    r.pte_protection  = PROT_W'($urandom);
    return r;
  endfunction

  function automatic request_t req_of(logic [OPCODE_W-1:0] op, logic [VA_W-1:0] va,
                                      logic [FRAME_W-1:0] frame, logic valid,
                                      logic [PROT_W-1:0] prot);
    request_t r;
    r.opcode          = op;
    r.virtual_address = va;
    r.pte_frame       = frame;
    r.pte_valid       = valid;
    r.pte_protection  = prot;
    return r;
  endfunction

  // Queue a request with its lead-in gap; calm stretches send back to back
  task automatic plan(request_t r, bit drain);
    planned_request_t p;
    p.req   = r;
    p.drain = drain;
    if (calm_sends > 0) begin
      calm_sends--;
      p.gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 1) calm_sends = 50;
      p.gap = pick_gap();
    end
    request_plan.push_back(p);
  endtask

  // Insert at the hand, sweeping used entries first
  task automatic shadow_insert(logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame,
                               logic [PROT_W-1:0] prot);
    int guard;
    guard = 0;
    if (shadow_occupied[shadow_hand]) begin
      while (shadow_used[shadow_hand] && guard < ENTRIES) begin
        shadow_used[shadow_hand] = 0;
        shadow_hand = (shadow_hand + 1) % ENTRIES;
        guard++;
      end
    end
    shadow_page[shadow_hand]     = page;
    shadow_frame[shadow_hand]    = frame;
    shadow_prot[shadow_hand]     = prot;
    shadow_occupied[shadow_hand] = 1;
    shadow_used[shadow_hand]     = 1;
    shadow_hand = (shadow_hand + 1) % ENTRIES;
  endtask

  // Advance the shadow buffer by one request and form its translation
  task automatic predict_translation(input request_t rq, output bit produced,
                                     output result_t res);
    logic [PAGE_W-1:0] page;
    bit found;
    res      = '0;
    produced = 1;
    found    = 0;
    page     = rq.virtual_address[VA_W-1:OFFSET_W];
    case (rq.opcode)
      OP_TRANSLATE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && shadow_occupied[i] && shadow_page[i] == page) begin
            found = 1;
            shadow_used[i] = 1;
            if (shadow_prot[i] == PROT_ALL) begin
              res.status = STATUS_PROT;
            end else begin
              res.status = STATUS_OK;
              res.physical_address = {shadow_frame[i], rq.virtual_address[OFFSET_W-1:0]};
            end
          end
        end
        if (!found) begin
          held_address = rq.virtual_address;
          held_valid = 1;
          res.status = STATUS_WALK;
          res.walk_address = {page, 2'b00};
        end
      end
      OP_REPLY: begin
        if (!held_valid) begin
          res.status = STATUS_STRAY;
        end else begin
          held_valid = 0;
          if (!rq.pte_valid) begin
            res.status = STATUS_SEGV;
          end else if (rq.pte_protection == PROT_ALL) begin
            res.status = STATUS_PROT;
          end else begin
            shadow_insert(held_address[VA_W-1:OFFSET_W], rq.pte_frame, rq.pte_protection);
            res.status = STATUS_OK;
            res.physical_address = {rq.pte_frame, held_address[OFFSET_W-1:0]};
          end
        end
      end
      OP_TICK: begin
        for (int i = 0; i < ENTRIES; i++) shadow_used[i] = 0;
        res.status = STATUS_TICK;
      end
      default: begin
        produced = 0;
      end
    endcase
  endtask

  // Present planned requests; predict each one as it is accepted
  always @(posedge clk) begin
    logic    next_push;
    bit      produced;
    result_t res;
    if (rst) begin
      push <= 1'b0;
      send_wait = 0;
    end else begin
      next_push = push;
      if (push && !full) begin
        predict_translation(request, produced, res);
        if (produced) translations_due.push_back(res);
        void'(request_plan.pop_front());
        next_push = 1'b0;
        send_wait = 0;
      end
      if (!next_push && request_plan.size() > 0) begin
        if (send_wait < request_plan[0].gap) begin
          send_wait++;
        end else if (!(request_plan[0].drain && translations_due.size() != 0)) begin
          request <= request_plan[0].req;
          next_push = 1'b1;
        end
      end
      push <= next_push;
    end
  end

  // Take results with random stalls and check them against the predictions
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
      pop_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (translations_due.size() == 0) begin
          $error("unexpected result: status %0d", result.status);
          failures++;
        end else begin
          want = translations_due.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            failures++;
          end
          if (result.physical_address !== want.physical_address) begin
            $error("physical_address: expected 0x%06h, actual 0x%06h",
                   want.physical_address, result.physical_address);
            failures++;
          end
          if (result.walk_address !== want.walk_address) begin
            $error("walk_address: expected 0x%02h, actual 0x%02h",
                   want.walk_address, result.walk_address);
            failures++;
          end
        end
        if (calm_pops > 0) begin
          calm_pops--;
          pop_wait = 0;
        end else begin
          if ($urandom_range(0, 99) < 2) calm_pops = 40;
          pop_wait = pick_gap();
        end
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int sent;
    int r;
    logic [PAGE_W-1:0] page;
    request_t rq;

    for (int i = 0; i < ENTRIES; i++) begin
      shadow_page[i]     = '0;
      shadow_frame[i]    = '0;
      shadow_prot[i]     = '0;
      shadow_occupied[i] = 0;
      shadow_used[i]     = 0;
    end
    shadow_hand  = 0;
    held_address = '0;
    held_valid   = 0;
    for (int i = 0; i < 24; i++) hot_pages[i] = $urandom_range(0, 63);

    // Directed: tick, stray reply, dropped opcode, field extremes, faults
    plan(req_of(OP_TICK, 16'h0000, 14'h0000, 1'b0, 3'd0), 0);
    plan(req_of(OP_REPLY, 16'hFFFF, 14'h3FFF, 1'b1, 3'd0), 0);
    plan(req_of(OP_NONE, 16'hFFFF, 14'h3FFF, 1'b1, 3'd7), 0);
    plan(req_of(OP_TRANSLATE, 16'h0000, 14'h0000, 1'b0, 3'd0), 0);
    plan(req_of(OP_REPLY, 16'h0000, 14'h3FFF, 1'b1, 3'd0), 0);
    plan(req_of(OP_TRANSLATE, 16'h03FF, 14'h3FFF, 1'b1, 3'd7), 0);
    plan(req_of(OP_TRANSLATE, 16'hFFFF, 14'h0000, 1'b0, 3'd0), 0);
    plan(req_of(OP_REPLY, 16'h0000, 14'h1234, 1'b1, PROT_ALL), 0);
    plan(req_of(OP_TRANSLATE, 16'hFFFF, 14'h0000, 1'b0, 3'd0), 0);
    plan(req_of(OP_REPLY, 16'h0000, 14'h3FFF, 1'b0, PROT_ALL), 0);
    plan(req_of(OP_TRANSLATE, 16'hFC00, 14'h0000, 1'b0, 3'd0), 0);
    plan(req_of(OP_REPLY, 16'h0000, 14'h0000, 1'b1, 3'd6), 0);
    plan(req_of(OP_TRANSLATE, 16'hFFFF, 14'h0000, 1'b0, 3'd0), 0);
    // A miss while a request is held replaces it
    plan(req_of(OP_TRANSLATE, 16'h1234, 14'h0000, 1'b0, 3'd0), 0);
    plan(req_of(OP_TRANSLATE, 16'h5678, 14'h0000, 1'b0, 3'd0), 0);
    plan(req_of(OP_REPLY, 16'h0000, 14'h2AAA, 1'b1, 3'd5), 0);
    // A hit while a request is held leaves it alone
    plan(req_of(OP_TRANSLATE, 16'h0800, 14'h0000, 1'b0, 3'd0), 0);
    plan(req_of(OP_TRANSLATE, 16'h0001, 14'h0000, 1'b0, 3'd0), 0);
    plan(req_of(OP_REPLY, 16'h0000, 14'h1555, 1'b1, 3'd3), 0);
    plan(req_of(OP_REPLY, 16'h0000, 14'h1555, 1'b1, 3'd3), 0);
    plan(req_of(OP_TICK, 16'hFFFF, 14'h3FFF, 1'b1, 3'd7), 0);
    // Wait here until every result so far has come out
    plan(req_of(OP_TRANSLATE, 16'h5400, 14'h0000, 1'b0, 3'd0), 1);
    plan(req_of(OP_TRANSLATE, 16'h1234, 14'h0000, 1'b0, 3'd0), 0);

    // Random: mostly translate and reply pairs over a hot page set
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      page = PAGE_W'(($urandom_range(0, 99) < 80) ? hot_pages[$urandom_range(0, 23)]
                                                  : $urandom_range(0, 63));
      r = $urandom_range(0, 99);
      rq = noisy_request(OP_TRANSLATE);
      rq.virtual_address[VA_W-1:OFFSET_W] = page;
      if (r < 60) begin
        plan(rq, sent == 0 || sent % 300 < 2);
        rq = noisy_request(OP_REPLY);
        rq.pte_valid = ($urandom_range(0, 99) < 90);
        rq.pte_protection = ($urandom_range(0, 99) < 10) ? PROT_ALL
                                                         : PROT_W'($urandom_range(0, 6));
        plan(rq, 0);
        sent += 2;
      end else if (r < 85) begin
        plan(rq, 0);
        sent++;
      end else if (r < 92) begin
        plan(noisy_request(OP_TICK), 0);
        sent++;
      end else if (r < 96) begin
        plan(noisy_request(OP_REPLY), 0);
        sent++;
      end else begin
        plan(noisy_request(OP_NONE), 0);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go in and every translation to come out
    do begin
      @(posedge clk);
      #1;
    end while (request_plan.size() != 0 || push || translations_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;

    if (failures == 0 && translations_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
